### design/lzssd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lzssd_pkg;

    localparam int WINDOW_DEPTH_DEF = 4096;
    localparam int BYTE_W           = 8;
    localparam int LEN_W            = 24;
    localparam int HDR_CNT_W        = 2;
    localparam int FLAG_CNT_W       = 4;
    localparam int COPY_CNT_W       = 5;

    localparam logic [BYTE_W-1:0]     MODE_LZSS   = 8'h20;
    localparam logic [BYTE_W-1:0]     MODE_STORED = 8'h00;
    localparam logic [COPY_CNT_W-1:0] MIN_MATCH   = 5'd3;
    localparam logic [HDR_CNT_W-1:0]  HDR_MODE    = 2'd3;
    localparam logic [FLAG_CNT_W-1:0] FLAG_BITS   = 4'd8;

    typedef struct packed {
        logic start_load;
        logic hdr_load;
        logic hdr_final;
        logic flag_load;
        logic lit;
        logic stored;
        logic low_load;
        logic match_load;
        logic copy_rd;
        logic copy_wr;
        logic item_done;
        logic emit_empty;
        logic empty_bad;
    } lzssd_cmd_t;

    typedef struct packed {
        logic out_free;
        logic hdr_last;
        logic rem_zero;
        logic rem_one;
        logic flag_lsb;
        logic bits_last;
        logic copy_last;
        logic mode_lzss;
        logic mode_stored;
    } lzssd_sts_t;

endpackage

`default_nettype wire

### design/lzssd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lzssd_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   s_tvalid,
    input  wire                   entity_start,
    input  lzssd_pkg::lzssd_sts_t sts,
    output lzssd_pkg::lzssd_cmd_t cmd,
    output logic                  s_tready
);
    import lzssd_pkg::*;

    typedef enum logic [7:0] {
        S_WAIT     = 8'b0000_0001,
        S_HEADER   = 8'b0000_0010,
        S_FLAG     = 8'b0000_0100,
        S_DATA     = 8'b0000_1000,
        S_MATCH_HI = 8'b0001_0000,
        S_STORED   = 8'b0010_0000,
        S_COPY_RD  = 8'b0100_0000,
        S_COPY_WR  = 8'b1000_0000
    } lzssd_state_t;

    lzssd_state_t state_reg;
    lzssd_state_t state_next;
    lzssd_state_t after_item;
    logic         in_phase;
    logic         acc;

    assign in_phase = (state_reg != S_COPY_RD) && (state_reg != S_COPY_WR);
    assign s_tready = in_phase && sts.out_free;
    assign acc      = s_tvalid && s_tready;

    always_comb
    begin
        if (sts.rem_one)
            after_item = S_WAIT;
        else if (sts.bits_last)
            after_item = S_FLAG;
        else
            after_item = S_DATA;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        if (acc && entity_start)
        begin
            cmd.start_load = 1'b1;
            state_next     = S_HEADER;
        end
        else
        begin
            case (state_reg)
                S_WAIT:
                begin
                end
                S_HEADER:
                begin
                    if (acc)
                    begin
                        if (!sts.hdr_last)
                            cmd.hdr_load = 1'b1;
                        else
                        begin
                            cmd.hdr_final = 1'b1;
                            if (!sts.mode_lzss && !sts.mode_stored)
                            begin
                                cmd.emit_empty = 1'b1;
                                cmd.empty_bad  = 1'b1;
                                state_next     = S_WAIT;
                            end
                            else if (sts.rem_zero)
                            begin
                                cmd.emit_empty = 1'b1;
                                state_next     = S_WAIT;
                            end
                            else if (sts.mode_lzss)
                                state_next = S_FLAG;
                            else
                                state_next = S_STORED;
                        end
                    end
                end
                S_STORED:
                begin
                    if (acc)
                    begin
                        cmd.stored = 1'b1;
                        if (sts.rem_one)
                            state_next = S_WAIT;
                    end
                end
                S_FLAG:
                begin
                    if (acc)
                    begin
                        cmd.flag_load = 1'b1;
                        state_next    = S_DATA;
                    end
                end
                S_DATA:
                begin
                    if (acc)
                    begin
                        if (sts.flag_lsb)
                        begin
                            cmd.lit       = 1'b1;
                            cmd.item_done = 1'b1;
                            state_next    = after_item;
                        end
                        else
                        begin
                            cmd.low_load = 1'b1;
                            state_next   = S_MATCH_HI;
                        end
                    end
                end
                S_MATCH_HI:
                begin
                    if (acc)
                    begin
                        cmd.match_load = 1'b1;
                        state_next     = S_COPY_RD;
                    end
                end
                S_COPY_RD:
                begin
                    cmd.copy_rd = 1'b1;
                    state_next  = S_COPY_WR;
                end
                S_COPY_WR:
                begin
                    if (sts.out_free)
                    begin
                        cmd.copy_wr = 1'b1;
                        if (sts.copy_last || sts.rem_one)
                        begin
                            cmd.item_done = 1'b1;
                            state_next    = after_item;
                        end
                        else
                            state_next = S_COPY_RD;
                    end
                end
                default:
                begin
                    state_next = S_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_WAIT;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

### design/lzssd_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module lzssd_dp #(
    parameter int WINDOW_DEPTH = lzssd_pkg::WINDOW_DEPTH_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire  [7:0]            in_byte,
    input  lzssd_pkg::lzssd_cmd_t cmd,
    output lzssd_pkg::lzssd_sts_t sts,
    input  wire                   m_tready,
    output logic                  m_tvalid,
    output logic [7:0]            out_byte,
    output logic                  has_data,
    output logic                  last,
    output logic                  status
);
    import lzssd_pkg::*;

    localparam int ADDR_W = $clog2(WINDOW_DEPTH);

    logic [LEN_W-1:0]      rem_reg,     rem_next;
    logic [HDR_CNT_W-1:0]  hc_reg,      hc_next;
    logic [BYTE_W-1:0]     flag_reg,    flag_next;
    logic [FLAG_CNT_W-1:0] bits_reg,    bits_next;
    logic [BYTE_W-1:0]     low_reg,     low_next;
    logic [ADDR_W-1:0]     wr_idx_reg,  wr_idx_next;
    logic                  wrapped_reg, wrapped_next;
    logic [ADDR_W-1:0]     pos_reg,     pos_next;
    logic [COPY_CNT_W-1:0] len_reg,     len_next;
    logic                  out_valid_reg, out_valid_next;

    logic [BYTE_W-1:0]     rd_data_reg;
    logic                  rd_valid_reg;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic                  out_has_reg;
    logic                  out_last_reg;
    logic                  out_bad_reg;

    logic [BYTE_W-1:0]     mem [WINDOW_DEPTH];
    logic [BYTE_W-1:0]     copy_byte;
    logic [BYTE_W-1:0]     wr_data;
    logic                  wr_en;
    logic                  emit;
    logic [2*BYTE_W-1:0]   code;

    assign copy_byte = rd_valid_reg ? rd_data_reg : '0;
    assign wr_en     = cmd.lit || cmd.copy_wr;
    assign wr_data   = cmd.lit ? in_byte : copy_byte;
    assign emit      = cmd.lit || cmd.stored || cmd.copy_wr || cmd.emit_empty;
    assign code      = {in_byte, low_reg};

    always_comb
    begin
        sts.out_free    = !out_valid_reg || m_tready;
        sts.hdr_last    = (hc_reg == HDR_MODE);
        sts.rem_zero    = (rem_reg == '0);
        sts.rem_one     = (rem_reg == LEN_W'(1));
        sts.flag_lsb    = flag_reg[0];
        sts.bits_last   = (bits_reg <= FLAG_CNT_W'(1));
        sts.copy_last   = (len_reg == COPY_CNT_W'(1));
        sts.mode_lzss   = (in_byte == MODE_LZSS);
        sts.mode_stored = (in_byte == MODE_STORED);
    end

    always_comb
    begin
        rem_next     = rem_reg;
        hc_next      = hc_reg;
        flag_next    = flag_reg;
        bits_next    = bits_reg;
        low_next     = low_reg;
        wr_idx_next  = wr_idx_reg;
        wrapped_next = wrapped_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;

        if (cmd.start_load)
        begin
            rem_next     = {{(LEN_W-BYTE_W){1'b0}}, in_byte};
            hc_next      = HDR_CNT_W'(1);
            flag_next    = '0;
            bits_next    = '0;
            low_next     = '0;
            wr_idx_next  = '0;
            wrapped_next = 1'b0;
        end
        if (cmd.hdr_load)
        begin
            case (hc_reg)
                2'd1:    rem_next[15:8]  = in_byte;
                2'd2:    rem_next[23:16] = in_byte;
                default: rem_next        = rem_reg;
            endcase
            hc_next = hc_reg + HDR_CNT_W'(1);
        end
        if (cmd.hdr_final)
            hc_next = '0;
        if (cmd.flag_load)
        begin
            flag_next = in_byte;
            bits_next = FLAG_BITS;
        end
        if (cmd.item_done)
        begin
            flag_next = flag_reg >> 1;
            if (bits_reg != '0)
                bits_next = bits_reg - FLAG_CNT_W'(1);
        end
        if (cmd.low_load)
            low_next = in_byte;
        if (cmd.lit || cmd.stored || cmd.copy_wr)
            rem_next = rem_reg - LEN_W'(1);
        if (wr_en)
        begin
            wr_idx_next = wr_idx_reg + ADDR_W'(1);
            if (wr_idx_reg == ADDR_W'(WINDOW_DEPTH - 1))
                wrapped_next = 1'b1;
        end
        if (cmd.match_load)
        begin
            pos_next = code[ADDR_W-1:0];
            len_next = {1'b0, in_byte[7:4]} + MIN_MATCH;
        end
        if (cmd.copy_wr)
        begin
            pos_next = pos_reg + ADDR_W'(1);
            len_next = len_reg - COPY_CNT_W'(1);
        end
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            hc_reg        <= '0;
            flag_reg      <= '0;
            bits_reg      <= '0;
            low_reg       <= '0;
            wr_idx_reg    <= '0;
            wrapped_reg   <= 1'b0;
            pos_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            hc_reg        <= hc_next;
            flag_reg      <= flag_next;
            bits_reg      <= bits_next;
            low_reg       <= low_next;
            wr_idx_reg    <= wr_idx_next;
            wrapped_reg   <= wrapped_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx_reg] <= wr_data;
        if (cmd.copy_rd)
        begin
            rd_data_reg  <= mem[pos_reg];
            rd_valid_reg <= wrapped_reg || (pos_reg < wr_idx_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lit || cmd.stored)
        begin
            out_byte_reg <= in_byte;
            out_has_reg  <= 1'b1;
            out_last_reg <= sts.rem_one;
            out_bad_reg  <= 1'b0;
        end
        else if (cmd.copy_wr)
        begin
            out_byte_reg <= copy_byte;
            out_has_reg  <= 1'b1;
            out_last_reg <= sts.rem_one;
            out_bad_reg  <= 1'b0;
        end
        else if (cmd.emit_empty)
        begin
            out_byte_reg <= '0;
            out_has_reg  <= 1'b0;
            out_last_reg <= 1'b1;
            out_bad_reg  <= cmd.empty_bad;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign out_byte = out_byte_reg;
    assign has_data = out_has_reg;
    assign last     = out_last_reg;
    assign status   = out_bad_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> sts.out_free)
        else $error("result issued while output register is occupied");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.lit || cmd.stored || cmd.copy_wr) |-> (rem_reg != '0))
        else $error("byte produced past declared length");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_rd |-> (len_reg != '0))
        else $error("window read with exhausted copy length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bad_reg) |-> (out_last_reg && !out_has_reg))
        else $error("corrupt status on a data transaction");

endmodule

`default_nettype wire

### design/lzss_entity_decompressor.sv
// Literal, stored and empty results are registered in the output register when their
// transaction is accepted; a match code steps through S_COPY_RD (window read) and
// S_COPY_WR (window write and output) per copied byte, up to 18 bytes for the longest copy,
// and S_COPY_WR waits while the output register is occupied. Header, flag, stored and
// literal bytes are accepted back to back while the output is free; a copy holds off input.
// Reset: asynchronous, active-low rst_n clears control state; unwritten window reads give 0.
`timescale 1ns / 1ps
`default_nettype none

module lzss_entity_decompressor #(
    parameter int WINDOW_DEPTH = lzssd_pkg::WINDOW_DEPTH_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // [7:0] in_byte
    input  wire        s_tuser,   // [0] entity_start
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic [1:0] m_tuser    // [0] has_data, [1] status
);
    import lzssd_pkg::*;

    lzssd_cmd_t cmd;
    lzssd_sts_t sts;
    logic       has_data;
    logic       status;

    lzssd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .entity_start (s_tuser),
        .sts          (sts),
        .cmd          (cmd),
        .s_tready     (s_tready)
    );

    lzssd_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_byte  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .out_byte (m_tdata),
        .has_data (has_data),
        .last     (m_tlast),
        .status   (status)
    );

    assign m_tuser = {status, has_data};

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import lzssd_pkg::*;

    localparam int WINDOW_DEPTH = 4096;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 60;

    typedef enum int {
        DEC_WAIT,
        DEC_HEADER,
        DEC_FLAG,
        DEC_DATA,
        DEC_MATCH_HI,
        DEC_STORED
    } dec_phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_data;
        logic       last;
        logic       status;
    } decoded_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] in_byte
    logic       s_tuser;   // [0] entity_start
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] out_byte
    logic       m_tlast;
    logic [1:0] m_tuser;   // [0] has_data, [1] status

    dec_phase_t  dec_phase;
    int          dec_hdr_count;
    logic [23:0] dec_remaining;
    logic [7:0]  dec_flags;
    int          dec_flags_left;
    logic [7:0]  dec_match_lo;
    logic [11:0] dec_wr_ptr;
    logic [7:0]  dec_history [WINDOW_DEPTH];
    bit          dec_filled  [WINDOW_DEPTH];

    decoded_t decoded_queue[$];

    int errors;
    int items_sent;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int stall_cycles;

    lzss_entity_decompressor DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic void push_result(input logic [7:0] d, input logic h, input logic l,
                                        input logic s);
        decoded_t r;
        r.out_byte = d;
        r.has_data = h;
        r.last     = l;
        r.status   = s;
        decoded_queue.push_back(r);
    endfunction

    function automatic void write_window(input logic [7:0] d);
        dec_history[dec_wr_ptr] = d;
        dec_filled[dec_wr_ptr]  = 1'b1;
        dec_wr_ptr              = dec_wr_ptr + 12'd1;
    endfunction

    function automatic void next_item();
        dec_flags = dec_flags >> 1;
        if (dec_flags_left > 0)
        begin
            dec_flags_left--;
        end
        if (dec_remaining == 24'd0)
        begin
            dec_phase = DEC_WAIT;
        end
        else if (dec_flags_left == 0)
        begin
            dec_phase = DEC_FLAG;
        end
        else
        begin
            dec_phase = DEC_DATA;
        end
    endfunction

    function automatic void reset_decoder();
        dec_phase      = DEC_WAIT;
        dec_hdr_count  = 0;
        dec_remaining  = '0;
        dec_flags      = '0;
        dec_flags_left = 0;
        dec_match_lo   = '0;
        dec_wr_ptr     = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            dec_history[i] = 8'h00;
            dec_filled[i]  = 1'b0;
        end
    endfunction

    // Return 1 when the byte is consumed, 0 when it is dropped while waiting.
    function automatic bit decode_byte(input logic [7:0] b, input logic start);
        int          copy_len;
        logic [11:0] pos;
        logic [7:0]  v;
        if (start)
        begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                dec_filled[i] = 1'b0;
            end
            dec_wr_ptr     = '0;
            dec_flags      = '0;
            dec_flags_left = 0;
            dec_match_lo   = '0;
            dec_remaining  = {16'd0, b};
            dec_hdr_count  = 1;
            dec_phase      = DEC_HEADER;
            return 1'b1;
        end
        case (dec_phase)
            DEC_HEADER:
            begin
                if (dec_hdr_count < 3)
                begin
                    dec_remaining = dec_remaining | ({16'd0, b} << (8 * dec_hdr_count));
                    dec_hdr_count++;
                end
                else
                begin
                    dec_hdr_count = 0;
                    if (b != MODE_LZSS && b != MODE_STORED)
                    begin
                        dec_remaining = '0;
                        dec_phase     = DEC_WAIT;
                        push_result(8'h00, 1'b0, 1'b1, 1'b1);
                    end
                    else if (dec_remaining == 24'd0)
                    begin
                        dec_phase = DEC_WAIT;
                        push_result(8'h00, 1'b0, 1'b1, 1'b0);
                    end
                    else
                    begin
                        dec_phase = (b == MODE_LZSS) ? DEC_FLAG : DEC_STORED;
                    end
                end
            end
            DEC_STORED:
            begin
                dec_remaining = dec_remaining - 24'd1;
                if (dec_remaining == 24'd0)
                begin
                    dec_phase = DEC_WAIT;
                end
                push_result(b, 1'b1, dec_remaining == 24'd0, 1'b0);
            end
            DEC_FLAG:
            begin
                dec_flags      = b;
                dec_flags_left = 8;
                dec_phase      = DEC_DATA;
            end
            DEC_DATA:
            begin
                if (dec_flags[0])
                begin
                    write_window(b);
                    dec_remaining = dec_remaining - 24'd1;
                    push_result(b, 1'b1, dec_remaining == 24'd0, 1'b0);
                    next_item();
                end
                else
                begin
                    dec_match_lo = b;
                    dec_phase    = DEC_MATCH_HI;
                end
            end
            DEC_MATCH_HI:
            begin
                pos      = {b[3:0], dec_match_lo};
                copy_len = int'(b[7:4]) + int'(MIN_MATCH);
                while (copy_len > 0 && dec_remaining != 24'd0)
                begin
                    v = dec_filled[pos] ? dec_history[pos] : 8'h00;
                    write_window(v);
                    pos = pos + 12'd1;
                    copy_len--;
                    dec_remaining = dec_remaining - 24'd1;
                    push_result(v, 1'b1, dec_remaining == 24'd0, 1'b0);
                end
                next_item();
            end
            default:
            begin
                dec_phase = DEC_WAIT;
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        items_sent += int'(decode_byte(b, start));
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_results();
        stop_sending();
        while (decoded_queue.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_header(input logic [23:0] len, input logic [7:0] mode);
        send_byte(len[7:0], 1'b1);
        send_byte(len[15:8], 1'b0);
        send_byte(len[23:16], 1'b0);
        send_byte(mode, 1'b0);
    endtask

    task automatic send_stored(input int len, input int count);
        send_header(24'(len), MODE_STORED);
        for (int i = 0; i < count; i++)
        begin
            send_byte(8'($urandom), 1'b0);
        end
    endtask

    // Back-references point mostly into bytes already produced, overlapping ones included.
    task automatic send_lzss(input int len, input bit long_matches, input int max_bytes);
        int          produced;
        int          sent;
        int          nib;
        int          span;
        logic [7:0]  flags;
        logic [11:0] pos;
        send_header(24'(len), MODE_LZSS);
        produced = 0;
        sent     = 0;
        while (produced < len && sent < max_bytes)
        begin
            flags = long_matches ? 8'($urandom & $urandom & $urandom) : 8'($urandom);
            send_byte(flags, 1'b0);
            sent++;
            for (int i = 0; i < 8 && produced < len && sent < max_bytes; i++)
            begin
                if (flags[i])
                begin
                    send_byte(8'($urandom), 1'b0);
                    produced++;
                    sent++;
                end
                else
                begin
                    nib = long_matches ? $urandom_range(15, 12) : $urandom_range(15, 0);
                    if (produced > 0 && $urandom_range(3) != 0)
                    begin
                        span = (produced > WINDOW_DEPTH) ? WINDOW_DEPTH : produced;
                        pos  = 12'(produced - 1 - int'($urandom_range(span - 1, 0)));
                    end
                    else
                    begin
                        pos = 12'($urandom);
                    end
                    send_byte(pos[7:0], 1'b0);
                    send_byte({nib[3:0], pos[11:8]}, 1'b0);
                    produced += nib + 3;
                    sent += 2;
                end
            end
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_empty_and_corrupt();
        send_byte(8'h5A, 1'b0);
        send_header(24'd0, MODE_STORED);
        send_header(24'd0, MODE_LZSS);
        send_header(24'hFFFFFF, 8'hFF);
        send_byte(8'hA5, 1'b0);
    endtask

    task automatic test_stored_copy();
        send_header(24'd3, MODE_STORED);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h33, 1'b0);
    endtask

    task automatic test_lzss_items();
        send_header(24'd30, MODE_LZSS);
        send_byte(8'b0000_0011, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h77, 1'b0);
    endtask

    task automatic test_restart_mid_entity();
        send_header(24'hFFFFFF, MODE_STORED);
        send_byte(8'h11, 1'b0);
        send_byte(8'h02, 1'b1);
        send_byte(8'h00, 1'b0);
        send_header(24'd2, MODE_STORED);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
    endtask

    task automatic test_output_backpressure();
        set_idling(0, 0);
        hold_cycles = 400;
        send_stored(40, 40);
        wait_results();
    endtask

    task automatic test_sender_pause();
        set_idling(0, 0);
        send_stored(60, 30);
        wait_results();
        for (int i = 0; i < 30; i++)
        begin
            send_byte(8'($urandom), 1'b0);
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
        int target;
        int pick;
        int len;
        set_idling(send_pct, recv_pct);
        target = items_sent + count;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                send_lzss($urandom_range(60, 1), 1'b0, 1 << 30);
            end
            else if (pick < 72)
            begin
                len = $urandom_range(40, 1);
                send_stored(len, len + $urandom_range(2, 0));
            end
            else if (pick < 78)
            begin
                send_header($urandom_range(1) ? 24'd0 : 24'($urandom), 8'($urandom));
            end
            else if (pick < 84)
            begin
                send_header(24'($urandom), $urandom_range(1) ? MODE_LZSS : MODE_STORED);
                for (int i = $urandom_range(20, 0); i > 0; i--)
                begin
                    send_byte(8'($urandom), 1'b0);
                end
            end
            else if (pick < 92)
            begin
                send_lzss($urandom_range(200, 20), 1'b0, $urandom_range(30, 1));
            end
            else
            begin
                send_byte(8'($urandom), 1'($urandom_range(1)));
                for (int i = $urandom_range(4, 0); i > 0; i--)
                begin
                    send_byte(8'($urandom), 1'b0);
                end
            end
        end
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        decoded_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decoded_queue.size() == 0)
            begin
                $error("unexpected result: out_byte %02h has_data %0b last %0b status %0b",
                       m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
                errors++;
            end
            else
            begin
                want = decoded_queue.pop_front();
                if (m_tdata !== want.out_byte)
                begin
                    $error("out_byte mismatch: expected %02h, actual %02h",
                           want.out_byte, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== want.has_data)
                begin
                    $error("has_data mismatch: expected %0b, actual %0b",
                           want.has_data, m_tuser[0]);
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last mismatch: expected %0b, actual %0b", want.last, m_tlast);
                    errors++;
                end
                if (m_tuser[1] !== want.status)
                begin
                    $error("status mismatch: expected %0b, actual %0b",
                           want.status, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        s_tuser        = 1'b0;
        errors         = 0;
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        stall_cycles   = 0;
        reset_decoder();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0, 0);
        test_empty_and_corrupt();
        test_stored_copy();
        test_lzss_items();
        test_restart_mid_entity();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic(0, 0, 60);
        test_random_traffic(75, 0, 60);
        test_random_traffic(0, 75, 60);
        test_random_traffic(7, 7, 60);

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
